// ===== hdl/mwcc_pkg.sv =====
// mwcc_pkg: shared types, register and width codes, and byte-order helpers
// used by the multi-width crc checker modules
// no dependencies
`default_nettype none

package mwcc_pkg;

  localparam int DATA_W = 8;
  localparam int CRC_W  = 64;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 4;

  localparam logic [MODE_W-1:0] MODE_W8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_W16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_W32 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_W64 = 2'd3;

  localparam logic REG_WIDTH_MODE = 1'b0;
  localparam logic REG_POLYNOMIAL = 1'b1;

  typedef struct packed {
    logic [CRC_W-1:0]  expected_crc;
    logic              last_byte;
    logic [DATA_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc_value;
    logic             crc_match;
  } result_t;

  function automatic logic [CRC_W-1:0] width_mask(input logic [MODE_W-1:0] mode);
    logic [CRC_W-1:0] m;
    unique case (mode)
      MODE_W8:  m = {{(CRC_W-8){1'b0}}, {8{1'b1}}};
      MODE_W16: m = {{(CRC_W-16){1'b0}}, {16{1'b1}}};
      MODE_W32: m = {{(CRC_W-32){1'b0}}, {32{1'b1}}};
      default:  m = {CRC_W{1'b1}};
    endcase
    return m;
  endfunction

  function automatic logic [CRC_W-1:0] top_bit(input logic [MODE_W-1:0] mode);
    logic [CRC_W-1:0] t;
    unique case (mode)
      MODE_W8:  t = {{(CRC_W-8){1'b0}}, 1'b1, 7'b0};
      MODE_W16: t = {{(CRC_W-16){1'b0}}, 1'b1, 15'b0};
      MODE_W32: t = {{(CRC_W-32){1'b0}}, 1'b1, 31'b0};
      default:  t = {1'b1, {(CRC_W-1){1'b0}}};
    endcase
    return t;
  endfunction

  // reverse the low crc-width bytes, upper bytes zero
  function automatic logic [CRC_W-1:0] swap_bytes(input logic [CRC_W-1:0] v,
                                                  input logic [MODE_W-1:0] mode);
    logic [CRC_W-1:0] r;
    unique case (mode)
      MODE_W8:  r = {{(CRC_W-8){1'b0}}, v[7:0]};
      MODE_W16: r = {{(CRC_W-16){1'b0}}, v[7:0], v[15:8]};
      MODE_W32: r = {{(CRC_W-32){1'b0}}, v[7:0], v[15:8], v[23:16], v[31:24]};
      default:  r = {v[7:0], v[15:8], v[23:16], v[31:24],
                     v[39:32], v[47:40], v[55:48], v[63:56]};
    endcase
    return r;
  endfunction

  // place the message byte at the top of the crc width
  function automatic logic [CRC_W-1:0] align_byte(input logic [DATA_W-1:0] d,
                                                  input logic [MODE_W-1:0] mode);
    logic [CRC_W-1:0] a;
    unique case (mode)
      MODE_W8:  a = {{(CRC_W-8){1'b0}}, d};
      MODE_W16: a = {{(CRC_W-16){1'b0}}, d, 8'b0};
      MODE_W32: a = {{(CRC_W-32){1'b0}}, d, 24'b0};
      default:  a = {d, {(CRC_W-8){1'b0}}};
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mwcc_update.sv =====
// mwcc_update: one-byte msb-first crc update over the selected width,
// byte-order conversion of the result and the checksum compare
// depends on mwcc_pkg
`default_nettype none

module mwcc_update (
  input  wire logic [mwcc_pkg::MODE_W-1:0] width_mode,
  input  wire logic [mwcc_pkg::CRC_W-1:0]  polynomial,
  input  wire logic [mwcc_pkg::CRC_W-1:0]  crc_in,
  input  wire mwcc_pkg::item_t             item,
  output mwcc_pkg::result_t                result,
  output logic [mwcc_pkg::CRC_W-1:0]       crc_out
);

  logic [mwcc_pkg::CRC_W-1:0] mask;
  logic [mwcc_pkg::CRC_W-1:0] top;
  logic [mwcc_pkg::CRC_W-1:0] poly;
  logic [mwcc_pkg::CRC_W-1:0] crc;
  logic [mwcc_pkg::CRC_W-1:0] rep;

  always_comb begin
    mask = mwcc_pkg::width_mask(width_mode);
    top  = mwcc_pkg::top_bit(width_mode);
    poly = mwcc_pkg::swap_bytes(polynomial, width_mode);
    crc  = (crc_in & mask) ^ mwcc_pkg::align_byte(item.data_byte, width_mode);
    for (int i = 0; i < mwcc_pkg::DATA_W; i++) begin
      if ((crc & top) != '0) begin
        crc = ((crc << 1) ^ poly) & mask;
      end else begin
        crc = (crc << 1) & mask;
      end
    end
    rep = mwcc_pkg::swap_bytes(crc, width_mode);
    crc_out = crc;
    result.crc_value = rep;
    result.crc_match = (rep == (item.expected_crc & mask));
  end

endmodule

`default_nettype wire

// ===== hdl/multi_width_crc_checker.sv =====
// multi_width_crc_checker: top level with config registers, crc state memory,
// update stage with forwarding and the output register
// depends on mwcc_pkg and mwcc_update
//
// One message byte is taken per clock cycle, back to back. An accepted item
// reads the running crc from a one-entry synchronous memory, passes through
// the stage register and the unrolled eight-bit update and, as it advances,
// writes the memory back; an item that follows directly gets the written
// value forwarded. A last byte's result is loaded into the output register
// as that item advances; input stalls only while a result waits and the next
// last byte needs that register. The crc value and polynomial are in file
// byte order, byte-reversed over the width; crc value bits above it read zero.
`default_nettype none

module multi_width_crc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] data_byte, [71:8] expected_crc
  input  wire logic [71:0] in_tdata,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [63:0] crc_value
  output logic [63:0]      out_tdata,
  // [0] crc_match
  output logic [0:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [mwcc_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [mwcc_pkg::MODE_W-1:0] width_mode_r;
  logic [mwcc_pkg::CRC_W-1:0]  polynomial_r;
  logic                        cfg_wr;

  mwcc_pkg::item_t             in_item;
  mwcc_pkg::item_t             s1_item_r;
  logic                        s1_vld_r;
  logic                        s1_vld_nxt;
  logic                        s1_adv;
  logic                        in_acc;

  logic [mwcc_pkg::CRC_W-1:0]  crc_mem [1];
  logic                        mem_vld_r;
  logic [mwcc_pkg::CRC_W-1:0]  rd_data_r;
  logic                        fwd_r;
  logic [mwcc_pkg::CRC_W-1:0]  fwd_data_r;
  logic [mwcc_pkg::CRC_W-1:0]  crc_cur;
  logic [mwcc_pkg::CRC_W-1:0]  crc_upd;
  logic [mwcc_pkg::CRC_W-1:0]  wr_data;
  logic                        mem_wr;

  mwcc_pkg::result_t           res;
  mwcc_pkg::result_t           out_r;
  logic                        out_vld_r;
  logic                        out_vld_nxt;
  logic                        out_load;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= mwcc_pkg::MODE_W8;
      polynomial_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        mwcc_pkg::REG_WIDTH_MODE: width_mode_r <= cfg_pwdata[mwcc_pkg::MODE_W-1:0];
        mwcc_pkg::REG_POLYNOMIAL: polynomial_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3])
      mwcc_pkg::REG_WIDTH_MODE:
        cfg_prdata = {{(64-mwcc_pkg::MODE_W){1'b0}}, width_mode_r};
      default: cfg_prdata = polynomial_r;
    endcase
  end

  // input stage
  assign in_item.data_byte    = in_tdata[7:0];
  assign in_item.expected_crc = in_tdata[71:8];
  assign in_item.last_byte    = in_tlast;

  assign s1_adv    = s1_vld_r && (!s1_item_r.last_byte || !out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_vld_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  // crc state memory, read on accept, written back from the update stage
  assign mem_wr  = s1_adv;
  assign wr_data = s1_item_r.last_byte ? '0 : crc_upd;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      crc_mem[0] <= wr_data;
    end
    if (in_acc) begin
      rd_data_r <= mem_vld_r ? crc_mem[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (mem_wr) begin
        mem_vld_r <= 1'b1;
      end
      if (in_acc) begin
        fwd_r <= mem_wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && mem_wr) begin
      fwd_data_r <= wr_data;
    end
  end

  assign crc_cur = fwd_r ? fwd_data_r : rd_data_r;

  mwcc_update u_update (
    .width_mode (width_mode_r),
    .polynomial (polynomial_r),
    .crc_in     (crc_cur),
    .item       (s1_item_r),
    .result     (res),
    .crc_out    (crc_upd)
  );

  // output register
  assign out_load    = s1_adv && s1_item_r.last_byte;
  assign out_vld_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_r.crc_value;
  assign out_tuser[0] = out_r.crc_match;

endmodule

`default_nettype wire

// ===== hdl/mwcc_checker.sv =====
// mwcc_checker: port-level assertions for the multi-width crc checker
// bound to multi_width_crc_checker; depends on no other file
`default_nettype none

module mwcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        cfg_pready
);

  // a result waiting for the sink holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // input backpressure comes only from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a blocked result");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port not ready");

endmodule

bind multi_width_crc_checker mwcc_checker u_mwcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

// ===== dv/crc_result_checker.sv =====
// crc_result_checker: watches the byte, result and register ports of the crc checker,
// keeps its own crc state, predicts every checksum report and compares it field by field
// depends on mwcc_pkg for the result type, width codes and register codes
`timescale 1ns / 1ps

module crc_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  // [7:0] data_byte, [71:8] expected_crc
  input  logic [71:0]                 in_tdata,
  input  logic                        in_tlast,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // [63:0] crc_value
  input  logic [63:0]                 out_tdata,
  // [0] crc_match
  input  logic [0:0]                  out_tuser,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mwcc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [63:0]                 cfg_pwdata,
  input  logic [63:0]                 cfg_prdata,
  input  logic                        cfg_pready,
  output int                          fail_count,
  output int                          pending,
  output int                          report_count,
  output int                          match_count,
  output logic [63:0]                 last_crc
);

  localparam logic [mwcc_pkg::ADDR_W-1:0] WIDTH_MODE_ADDR = {mwcc_pkg::REG_WIDTH_MODE, 3'b000};
  localparam logic [mwcc_pkg::ADDR_W-1:0] POLYNOMIAL_ADDR = {mwcc_pkg::REG_POLYNOMIAL, 3'b000};

  mwcc_pkg::result_t crc_reports[$];
  mwcc_pkg::result_t want;
  logic [1:0]       width_sel;
  logic [63:0]      poly_file;
  logic [63:0]      crc_state;
  logic [63:0]      crc_next;
  logic [63:0]      reported;
  logic [63:0]      rd_want;
  int               errors;
  int               reports;
  int               match_total;

  function automatic logic [63:0] crc_mask(input logic [1:0] mode);
    return (mode == mwcc_pkg::MODE_W64) ? '1 : ((64'd1 << (8 << mode)) - 64'd1);
  endfunction

  // reverse the low nbytes bytes, upper bytes zero
  function automatic logic [63:0] reorder_bytes(input logic [63:0] v, input int nbytes);
    logic [63:0] r;
    int          k;
    r = '0;
    for (k = 0; k < nbytes; k++) r[(nbytes-1-k)*8 +: 8] = v[k*8 +: 8];
    return r;
  endfunction

  // msb-first update of the running crc by one message byte
  function automatic logic [63:0] crc_after_byte(input logic [63:0] crc_in,
                                                 input logic [7:0]  d,
                                                 input logic [1:0]  mode,
                                                 input logic [63:0] poly_in);
    int          nbytes;
    int          w;
    int          i;
    logic [63:0] mask;
    logic [63:0] poly;
    logic [63:0] crc;
    nbytes = 1 << mode;
    w      = 8 * nbytes;
    mask   = crc_mask(mode);
    poly   = reorder_bytes(poly_in & mask, nbytes);
    crc    = (crc_in & mask) ^ (64'(d) << (w - 8));
    for (i = 0; i < 8; i++) begin
      if (crc[w-1]) crc = ((crc << 1) ^ poly) & mask;
      else crc = (crc << 1) & mask;
    end
    return crc;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      crc_reports.delete();
      width_sel   = mwcc_pkg::MODE_W8;
      poly_file   = '0;
      crc_state   = '0;
      errors      = 0;
      reports     = 0;
      match_total = 0;
      last_crc  <= '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (crc_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual crc_value=%h crc_match=%0b",
                   $time, out_tdata, out_tuser[0]);
        end else begin
          want = crc_reports.pop_front();
          if (want.crc_value !== out_tdata) begin
            errors++;
            $display("%0t: crc_value mismatch, expected %h actual %h",
                     $time, want.crc_value, out_tdata);
          end
          if (want.crc_match !== out_tuser[0]) begin
            errors++;
            $display("%0t: crc_match mismatch, expected %0b actual %0b",
                     $time, want.crc_match, out_tuser[0]);
          end
        end
        reports++;
        if (out_tuser[0] === 1'b1) match_total++;
        last_crc <= out_tdata;
      end

      if (in_tvalid && in_tready) begin
        crc_next = crc_after_byte(crc_state, in_tdata[7:0], width_sel, poly_file);
        if (in_tlast) begin
          reported        = reorder_bytes(crc_next, 1 << width_sel);
          want.crc_value  = reported;
          want.crc_match  = (reported == (in_tdata[71:8] & crc_mask(width_sel)));
          crc_reports.push_back(want);
          crc_state = '0;
        end else begin
          crc_state = crc_next;
        end
      end

      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr)
            WIDTH_MODE_ADDR: width_sel = cfg_pwdata[1:0];
            POLYNOMIAL_ADDR: poly_file = cfg_pwdata;
            default: ;
          endcase
        end else if (cfg_paddr == WIDTH_MODE_ADDR || cfg_paddr == POLYNOMIAL_ADDR) begin
          rd_want = (cfg_paddr == WIDTH_MODE_ADDR) ? 64'(width_sel) : poly_file;
          if (cfg_prdata !== rd_want) begin
            errors++;
            $display("%0t: register read at %h, expected %h actual %h",
                     $time, cfg_paddr, rd_want, cfg_prdata);
          end
        end
      end
    end
    fail_count   <= errors;
    pending      <= crc_reports.size();
    report_count <= reports;
    match_count  <= match_total;
  end

endmodule

// ===== dv/testbench.sv =====
// testbench: clock, reset, byte and register stimulus for the multi-width crc checker
// depends on mwcc_pkg, multi_width_crc_checker and crc_result_checker
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 4000;
  localparam logic [mwcc_pkg::ADDR_W-1:0] WIDTH_MODE_ADDR = {mwcc_pkg::REG_WIDTH_MODE, 3'b000};
  localparam logic [mwcc_pkg::ADDR_W-1:0] POLYNOMIAL_ADDR = {mwcc_pkg::REG_POLYNOMIAL, 3'b000};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [71:0]       in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [mwcc_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [63:0]       cfg_pwdata = '0;
  logic [63:0]       cfg_prdata;
  logic              cfg_pready;

  int                fail_count;
  int                pending;
  int                report_count;
  int                match_count;
  logic [63:0]       last_crc;

  int                idle_in = 0;
  int                idle_out = 0;
  int                stall_cycles = 0;
  int                items_sent = 0;
  logic [1:0]        cur_mode = mwcc_pkg::MODE_W8;
  bit                msg_fresh = 1'b1;

  always #1 clk = ~clk;

  multi_width_crc_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  crc_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .report_count(report_count),
    .match_count (match_count),
    .last_crc    (last_crc)
  );

  always @(posedge clk) out_tready <= ($urandom_range(99) >= idle_out);

  // watchdog on cycles with no item, result or register access
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] width_bits(input logic [1:0] mode);
    return (mode == mwcc_pkg::MODE_W64) ? '1 : ((64'd1 << (8 << mode)) - 64'd1);
  endfunction

  task automatic apb_access(input bit write, input logic [mwcc_pkg::ADDR_W-1:0] addr,
                            input logic [63:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] d, input bit last, input logic [63:0] chk);
    bit ready_seen;
    while ($urandom_range(99) < idle_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {chk, d};
    in_tlast  <= last;
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    items_sent++;
    if (last) msg_fresh = 1'b1;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // block may still be busy on a byte without a result
  task automatic wait_idle();
    wait_drain();
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [63:0] poly);
    wait_idle();
    apb_access(1'b1, WIDTH_MODE_ADDR, {$urandom, $urandom_range(32'hffff_ffff) & ~32'h3} | mode);
    apb_access(1'b1, POLYNOMIAL_ADDR, poly);
    apb_access(1'b0, WIDTH_MODE_ADDR, '0);
    apb_access(1'b0, POLYNOMIAL_ADDR, '0);
    cur_mode = mode;
  endtask

  task automatic send_check_string(input logic [63:0] chk);
    int k;
    for (k = 1; k <= 9; k++) send_item(8'h30 + k[7:0], k == 9, chk);
  endtask

  task automatic run_segment(input int n_items);
    logic [7:0]  msg [0:47];
    logic [63:0] chk;
    int          len;
    int          k;
    int          count;
    bit          fresh_start;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
      fresh_start = msg_fresh;
      for (k = 0; k < len; k++) msg[k] = 8'($urandom_range(255));
      for (k = 0; k < len; k++) send_item(msg[k], k == len - 1, {$urandom, $urandom});
      count += len;
      // resend a clean message with its real checksum, sometimes off by one bit
      if (fresh_start && $urandom_range(2) == 0) begin
        wait_drain();
        chk = last_crc | ({$urandom, $urandom} & ~width_bits(cur_mode));
        if ($urandom_range(3) == 0) chk ^= 64'd1 << $urandom_range(8 * (1 << cur_mode) - 1);
        for (k = 0; k < len; k++) send_item(msg[k], k == len - 1, chk);
        count += len;
      end
    end
    // leave a message open across the next register change
    if ($urandom_range(2) == 0) begin
      len = $urandom_range(5, 1);
      for (k = 0; k < len; k++) send_item(8'($urandom_range(255)), 1'b0, {$urandom, $urandom});
      msg_fresh = 1'b0;
    end
  endtask

  initial begin
    int          phase;
    int          seg;
    logic [1:0]  mode;
    logic [63:0] poly;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then known check strings
    apb_access(1'b0, WIDTH_MODE_ADDR, '0);
    apb_access(1'b0, POLYNOMIAL_ADDR, '0);
    send_item(8'hff, 1'b1, 64'h0);
    set_config(mwcc_pkg::MODE_W8, 64'h07);
    send_check_string(64'hffff_ffff_ffff_fff4);
    set_config(mwcc_pkg::MODE_W16, 64'hdead_beef_0000_2110);
    send_item(8'h80, 1'b1, '1);
    set_config(mwcc_pkg::MODE_W64, 64'h9336_eaa9_ebe1_f042);
    send_check_string(64'h4773_490b_5fdf_406c);
    set_config(mwcc_pkg::MODE_W32, '1);
    send_item(8'h00, 1'b0, '0);
    send_item(8'hff, 1'b1, 64'h5a5a_a5a5_0f0f_f0f0);

    for (phase = 0; phase < 3; phase++) begin
      idle_in  = (phase == 0) ? 26 : (phase == 1) ? 88 : 0;
      idle_out = (phase == 0) ? 88 : (phase == 1) ? 26 : 0;
      for (seg = 0; seg < 6; seg++) begin
        mode = (seg < 4) ? seg[1:0] : 2'($urandom_range(3));
        case ($urandom_range(3))
          0:       poly = '0;
          1:       poly = '1;
          default: poly = {$urandom, $urandom};
        endcase
        set_config(mode, poly);
        run_segment(48);
      end
    end

    wait_idle();
    $display("run covered %0d bytes over all four crc widths and %0d register settings",
             items_sent, 4 + 3 * 6);
    $display("%0d checksum reports checked, %0d of them matching", report_count, match_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
